// ===== rtl/segi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, fixed-point constants, case codes and pipeline records shared by
// the segment intersection datapath and its quotient unit.
// ----------------------------------------------------------------------------
package segi_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQR_W   = 2 * DIFF_W;
   localparam int PROD_W  = 2 * DIFF_W + 1;
   localparam int MAG_W   = PROD_W;
   localparam int FRAC_W  = 16;
   localparam int PAR_W   = 32;
   localparam int PT_W    = 33;
   localparam int EPS_W   = 32;
   localparam int Q_W     = PAR_W + 1;
   localparam int DIV_SH  = Q_W - FRAC_W;
   localparam int DIV_LAT = Q_W + 3;
   localparam int MUL_W   = PAR_W + DIFF_W;
   localparam int SUM_W   = MUL_W + 1;

   localparam logic signed [PAR_W-1:0] PAR_MAX = {1'b0, {(PAR_W-1){1'b1}}};
   localparam logic signed [PAR_W-1:0] PAR_MIN = {1'b1, {(PAR_W-1){1'b0}}};
   localparam logic signed [PT_W-1:0]  PT_MAX  = {1'b0, {(PT_W-1){1'b1}}};
   localparam logic signed [PT_W-1:0]  PT_MIN  = {1'b1, {(PT_W-1){1'b0}}};
   localparam logic signed [PAR_W-1:0] ONE_FIX = PAR_W'(1) << FRAC_W;
   localparam logic signed [PAR_W-1:0] ZERO_FIX = '0;

   typedef enum logic [2:0] {
      CASE_PROPER     = 3'd0,
      CASE_BOTH_DEGEN = 3'd1,
      CASE_P_DEGEN    = 3'd2,
      CASE_Q_DEGEN    = 3'd3,
      CASE_COLLINEAR  = 3'd4,
      CASE_PARALLEL   = 3'd5
   } case_code_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [DIFF_W-1:0]  dp_x;
      logic signed [DIFF_W-1:0]  dp_y;
      logic signed [DIFF_W-1:0]  dq_x;
      logic signed [DIFF_W-1:0]  dq_y;
      logic signed [DIFF_W-1:0]  w_x;
      logic signed [DIFF_W-1:0]  w_y;
      logic                      p1q1;
      logic                      p1q2;
      logic                      q1p2;
   } diff_type;

   typedef struct packed {
      logic                      use_div;
      logic                      pinf;
      logic                      ptinf;
      case_code_type             code;
      logic signed [PAR_W-1:0]   alpha_fix;
      logic signed [PAR_W-1:0]   beta_fix;
      logic signed [COORD_W-1:0] p1_x;
      logic signed [COORD_W-1:0] p1_y;
      logic signed [DIFF_W-1:0]  dp_x;
      logic signed [DIFF_W-1:0]  dp_y;
   } side_type;

endpackage

// ===== rtl/segi_qdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection quotient unit
// Pipelined restoring divider for (num * 2^FRAC_W) / den, truncated toward
// zero and saturated to the parameter width, one quotient bit per stage.
// ----------------------------------------------------------------------------
module segi_qdiv import segi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [PROD_W-1:0] in_num,
   input  logic signed [PROD_W-1:0] in_den,
   output logic                     out_valid,
   output logic signed [PAR_W-1:0]  out_quo
);

   // Magnitude stage.
   logic [MAG_W-1:0] n_m_ff, d_m_ff;
   logic             neg_m_ff, vld_m_ff;

   always_ff @(posedge clock) begin
      n_m_ff   <= in_num[PROD_W-1] ? MAG_W'(-in_num) : MAG_W'(in_num);
      d_m_ff   <= in_den[PROD_W-1] ? MAG_W'(-in_den) : MAG_W'(in_den);
      neg_m_ff <= in_num[PROD_W-1] ^ in_den[PROD_W-1];
      if (reset) begin
         vld_m_ff <= 1'b0;
      end else begin
         vld_m_ff <= in_valid;
      end
   end

   // Step stages: index 0 holds the starting remainder.
   logic [MAG_W-1:0] rem_ff  [Q_W+1];
   logic [Q_W-1:0]   bits_ff [Q_W+1];
   logic [Q_W-1:0]   q_ff    [Q_W+1];
   logic [MAG_W-1:0] d_ff    [Q_W+1];
   logic             neg_ff  [Q_W+1];
   logic             ovf_ff  [Q_W+1];
   logic             dz_ff   [Q_W+1];
   logic             vld_ff  [Q_W+1];

   always_ff @(posedge clock) begin
      rem_ff[0]  <= MAG_W'(n_m_ff >> DIV_SH);
      bits_ff[0] <= {n_m_ff[DIV_SH-1:0], {FRAC_W{1'b0}}};
      q_ff[0]    <= '0;
      d_ff[0]    <= d_m_ff;
      neg_ff[0]  <= neg_m_ff;
      ovf_ff[0]  <= (MAG_W+DIV_SH)'(n_m_ff) >= {d_m_ff, {DIV_SH{1'b0}}};
      dz_ff[0]   <= (d_m_ff == '0);
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld_m_ff;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [MAG_W:0] rem_t;
      logic           ge;
      always_comb begin
         rem_t = {rem_ff[k], bits_ff[k][Q_W-1]};
         ge    = rem_t >= {1'b0, d_ff[k]};
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= ge ? MAG_W'(rem_t - {1'b0, d_ff[k]}) : MAG_W'(rem_t);
         bits_ff[k+1] <= bits_ff[k] << 1;
         q_ff[k+1]    <= {q_ff[k][Q_W-2:0], ge};
         d_ff[k+1]    <= d_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         ovf_ff[k+1]  <= ovf_ff[k];
         dz_ff[k+1]   <= dz_ff[k];
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   // Saturation stage.
   logic [Q_W-1:0]          q_fin;
   logic signed [PAR_W-1:0] quo_in;
   logic signed [PAR_W-1:0] quo_ff;
   logic                    out_vld_ff;

   always_comb begin
      q_fin = q_ff[Q_W];
      if (dz_ff[Q_W]) begin
         quo_in = PAR_MAX;
      end else if (ovf_ff[Q_W]) begin
         quo_in = neg_ff[Q_W] ? PAR_MIN : PAR_MAX;
      end else if (!neg_ff[Q_W]) begin
         quo_in = (q_fin > Q_W'(PAR_MAX)) ? PAR_MAX : PAR_W'(q_fin);
      end else begin
         quo_in = (q_fin > (Q_W'(1) << (PAR_W-1))) ? PAR_MIN
                                                  : PAR_W'(~q_fin[PAR_W-1:0] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[Q_W];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_quo   = quo_ff;

endmodule

// ===== rtl/segment_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment intersection
// Parametric intersection of two integer line segments in fixed point:
// alpha, beta (Q15.16), intersection point (Q16.16), case and hit flags.
// ----------------------------------------------------------------------------
//
// Channel   Ports                          Transaction
// -------   -----------------------------  ---------------------------------
// request   start, busy, req_*             start high while busy low
// response  rsp_valid, rsp_*               one cycle per result, no stall
// csr       csr_valid, csr_ready, csr_*    valid and ready both high
//
// Every transaction yields one response, after stages 1 to 4, the quotient
// units and stages E to G; a new transaction is accepted in every cycle in
// which busy is low. The quotient units retire one quotient bit per stage.
// Reset is synchronous and clears all valid bits; busy is high during reset.
// Nothing stalls: the response side takes every result as it appears.
//
module segment_intersection import segi_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_p1_x,
   input  logic signed [COORD_W-1:0] req_p1_y,
   input  logic signed [COORD_W-1:0] req_p2_x,
   input  logic signed [COORD_W-1:0] req_p2_y,
   input  logic signed [COORD_W-1:0] req_q1_x,
   input  logic signed [COORD_W-1:0] req_q1_y,
   input  logic signed [COORD_W-1:0] req_q2_x,
   input  logic signed [COORD_W-1:0] req_q2_y,
   output logic                      rsp_valid,
   output logic signed [PAR_W-1:0]   rsp_alpha,
   output logic signed [PAR_W-1:0]   rsp_beta,
   output logic signed [PT_W-1:0]    rsp_cross_x,
   output logic signed [PT_W-1:0]    rsp_cross_y,
   output logic                      rsp_params_infinite,
   output logic                      rsp_point_infinite,
   output logic                      rsp_hit,
   output logic [2:0]                rsp_case_code,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [EPS_W-1:0]          csr_epsilon
);

   // The pipeline never holds, so the only time the block refuses a
   // transaction is while it is in reset.
   logic req_accept;
   assign busy       = reset;
   assign req_accept = start && !busy;
   assign csr_ready  = 1'b1;

   logic [EPS_W-1:0] eps_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_epsilon;
      end
   end

   // Stage 1: difference vectors and endpoint equality.
   diff_type d1_in, d1_ff;
   logic     v1_ff;

   always_comb begin
      d1_in.p1_x = req_p1_x;
      d1_in.p1_y = req_p1_y;
      d1_in.dp_x = DIFF_W'(req_p2_x) - DIFF_W'(req_p1_x);
      d1_in.dp_y = DIFF_W'(req_p2_y) - DIFF_W'(req_p1_y);
      d1_in.dq_x = DIFF_W'(req_q1_x) - DIFF_W'(req_q2_x);
      d1_in.dq_y = DIFF_W'(req_q1_y) - DIFF_W'(req_q2_y);
      d1_in.w_x  = DIFF_W'(req_q1_x) - DIFF_W'(req_p1_x);
      d1_in.w_y  = DIFF_W'(req_q1_y) - DIFF_W'(req_p1_y);
      d1_in.p1q1 = (req_p1_x == req_q1_x) && (req_p1_y == req_q1_y);
      d1_in.p1q2 = (req_p1_x == req_q2_x) && (req_p1_y == req_q2_y);
      d1_in.q1p2 = (req_q1_x == req_p2_x) && (req_q1_y == req_p2_y);
   end

   always_ff @(posedge clock) begin
      d1_ff <= d1_in;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_accept;
      end
   end

   // Stage 2: all cross and square products. Note that the collinearity
   // cross product equals the beta numerator, so it is not formed twice.
   diff_type                 d2_ff;
   logic                     v2_ff;
   logic signed [SQR_W-1:0]  m_dpx_dqy_ff, m_dpy_dqx_ff, m_wx_dqy_ff, m_wy_dqx_ff;
   logic signed [SQR_W-1:0]  m_wy_dpx_ff, m_wx_dpy_ff;
   logic signed [SQR_W-1:0]  m_dpx2_ff, m_dpy2_ff, m_dqx2_ff, m_dqy2_ff;
   logic                     selp2_ff, selq2_ff;
   logic [DIFF_W-1:0]        a_dpx, a_dpy, a_dqx, a_dqy;

   always_comb begin
      a_dpx = d1_ff.dp_x[DIFF_W-1] ? DIFF_W'(-d1_ff.dp_x) : DIFF_W'(d1_ff.dp_x);
      a_dpy = d1_ff.dp_y[DIFF_W-1] ? DIFF_W'(-d1_ff.dp_y) : DIFF_W'(d1_ff.dp_y);
      a_dqx = d1_ff.dq_x[DIFF_W-1] ? DIFF_W'(-d1_ff.dq_x) : DIFF_W'(d1_ff.dq_x);
      a_dqy = d1_ff.dq_y[DIFF_W-1] ? DIFF_W'(-d1_ff.dq_y) : DIFF_W'(d1_ff.dq_y);
   end

   always_ff @(posedge clock) begin
      d2_ff        <= d1_ff;
      m_dpx_dqy_ff <= d1_ff.dp_x * d1_ff.dq_y;
      m_dpy_dqx_ff <= d1_ff.dp_y * d1_ff.dq_x;
      m_wx_dqy_ff  <= d1_ff.w_x * d1_ff.dq_y;
      m_wy_dqx_ff  <= d1_ff.w_y * d1_ff.dq_x;
      m_wy_dpx_ff  <= d1_ff.w_y * d1_ff.dp_x;
      m_wx_dpy_ff  <= d1_ff.w_x * d1_ff.dp_y;
      m_dpx2_ff    <= d1_ff.dp_x * d1_ff.dp_x;
      m_dpy2_ff    <= d1_ff.dp_y * d1_ff.dp_y;
      m_dqx2_ff    <= d1_ff.dq_x * d1_ff.dq_x;
      m_dqy2_ff    <= d1_ff.dq_y * d1_ff.dq_y;
      selp2_ff     <= a_dpx < a_dpy;
      selq2_ff     <= a_dqx < a_dqy;
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   // Stage 3: determinant, numerators and squared lengths.
   diff_type                d3_ff;
   logic                    v3_ff, selp3_ff, selq3_ff;
   logic signed [PROD_W-1:0] det_ff, na_ff, nb_ff;
   logic [SQR_W-1:0]         np_ff, nq_ff;

   always_ff @(posedge clock) begin
      d3_ff    <= d2_ff;
      selp3_ff <= selp2_ff;
      selq3_ff <= selq2_ff;
      det_ff   <= PROD_W'(m_dpx_dqy_ff) - PROD_W'(m_dpy_dqx_ff);
      na_ff    <= PROD_W'(m_wx_dqy_ff) - PROD_W'(m_wy_dqx_ff);
      nb_ff    <= PROD_W'(m_wy_dpx_ff) - PROD_W'(m_wx_dpy_ff);
      np_ff    <= SQR_W'(m_dpx2_ff) + SQR_W'(m_dpy2_ff);
      nq_ff    <= SQR_W'(m_dqx2_ff) + SQR_W'(m_dqy2_ff);
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   // Stage 4: classify the pair and pick the divider operands.
   logic [MAG_W-1:0]         det_mag, nb_mag;
   logic                     det_big, deg_p, deg_q, colin, match;
   side_type                 side4_in, side4_ff;
   logic signed [PROD_W-1:0] num_a_in, den_a_in, num_b_in, den_b_in;
   logic signed [PROD_W-1:0] num_a_ff, den_a_ff, num_b_ff, den_b_ff;
   logic                     v4_ff;

   always_comb begin
      det_mag = det_ff[PROD_W-1] ? MAG_W'(-det_ff) : MAG_W'(det_ff);
      nb_mag  = nb_ff[PROD_W-1] ? MAG_W'(-nb_ff) : MAG_W'(nb_ff);
      det_big = det_mag > MAG_W'(eps_ff);
      deg_p   = np_ff <= SQR_W'(eps_ff);
      deg_q   = nq_ff <= SQR_W'(eps_ff);
      colin   = nb_mag <= MAG_W'(eps_ff);
      match   = 1'b0;

      side4_in.use_div   = 1'b0;
      side4_in.pinf      = 1'b1;
      side4_in.ptinf     = 1'b1;
      side4_in.code      = CASE_PARALLEL;
      side4_in.alpha_fix = PAR_MAX;
      side4_in.beta_fix  = PAR_MAX;
      side4_in.p1_x      = d3_ff.p1_x;
      side4_in.p1_y      = d3_ff.p1_y;
      side4_in.dp_x      = d3_ff.dp_x;
      side4_in.dp_y      = d3_ff.dp_y;

      // Proper case divides by the determinant; the collinear case divides
      // along the dominant axis of each segment (x wins a tie).
      num_a_in = na_ff;
      den_a_in = det_ff;
      num_b_in = nb_ff;
      den_b_in = det_ff;

      if (det_big) begin
         side4_in.code    = CASE_PROPER;
         side4_in.use_div = 1'b1;
         side4_in.pinf    = 1'b0;
         side4_in.ptinf   = 1'b0;
      end else if (deg_p && deg_q) begin
         side4_in.code = CASE_BOTH_DEGEN;
         match         = d3_ff.p1q1 || d3_ff.p1q2;
         if (match) begin
            side4_in.alpha_fix = ZERO_FIX;
            side4_in.beta_fix  = ZERO_FIX;
         end
      end else if (deg_p) begin
         side4_in.code = CASE_P_DEGEN;
         match         = d3_ff.p1q1 || d3_ff.p1q2;
         if (match) begin
            side4_in.alpha_fix = ZERO_FIX;
            side4_in.beta_fix  = d3_ff.p1q1 ? ZERO_FIX : ONE_FIX;
         end
      end else if (deg_q) begin
         side4_in.code = CASE_Q_DEGEN;
         match         = d3_ff.p1q1 || d3_ff.q1p2;
         if (match) begin
            side4_in.alpha_fix = d3_ff.p1q1 ? ZERO_FIX : ONE_FIX;
            side4_in.beta_fix  = ZERO_FIX;
         end
      end else if (colin) begin
         side4_in.code    = CASE_COLLINEAR;
         side4_in.use_div = 1'b1;
         side4_in.pinf    = 1'b0;
         num_a_in = selp3_ff ? PROD_W'(d3_ff.w_y) : PROD_W'(d3_ff.w_x);
         den_a_in = selp3_ff ? PROD_W'(d3_ff.dp_y) : PROD_W'(d3_ff.dp_x);
         num_b_in = selq3_ff ? PROD_W'(d3_ff.w_y) : PROD_W'(d3_ff.w_x);
         den_b_in = selq3_ff ? PROD_W'(d3_ff.dq_y) : PROD_W'(d3_ff.dq_x);
      end

      if (match) begin
         side4_in.pinf  = 1'b0;
         side4_in.ptinf = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      side4_ff <= side4_in;
      num_a_ff <= num_a_in;
      den_a_ff <= den_a_in;
      num_b_ff <= num_b_in;
      den_b_ff <= den_b_in;
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   // Quotient units, with the side record delayed to match.
   logic                    va_out, vb_out;
   logic signed [PAR_W-1:0] quo_a, quo_b;

   segi_qdiv u_div_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_num    (num_a_ff),
      .in_den    (den_a_ff),
      .out_valid (va_out),
      .out_quo   (quo_a)
   );

   segi_qdiv u_div_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_num    (num_b_ff),
      .in_den    (den_b_ff),
      .out_valid (vb_out),
      .out_quo   (quo_b)
   );

   side_type side_ff [DIV_LAT];

   always_ff @(posedge clock) begin
      side_ff[0] <= side4_ff;
      for (int i = 1; i < DIV_LAT; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   // Stage E: final parameters.
   side_type                side_e_ff;
   logic signed [PAR_W-1:0] alpha_e_ff, beta_e_ff;
   logic                    ve_ff;

   always_ff @(posedge clock) begin
      side_e_ff  <= side_ff[DIV_LAT-1];
      alpha_e_ff <= side_ff[DIV_LAT-1].use_div ? quo_a : side_ff[DIV_LAT-1].alpha_fix;
      beta_e_ff  <= side_ff[DIV_LAT-1].use_div ? quo_b : side_ff[DIV_LAT-1].beta_fix;
      if (reset) begin
         ve_ff <= 1'b0;
      end else begin
         ve_ff <= va_out;
      end
   end

   // Stage F: point offsets alpha * dp and the hit test.
   side_type                side_f_ff;
   logic signed [PAR_W-1:0] alpha_f_ff, beta_f_ff;
   logic signed [MUL_W-1:0] mx_ff, my_ff;
   logic                    hit_f_ff, vf_ff;

   always_ff @(posedge clock) begin
      side_f_ff  <= side_e_ff;
      alpha_f_ff <= alpha_e_ff;
      beta_f_ff  <= beta_e_ff;
      mx_ff      <= MUL_W'(alpha_e_ff) * MUL_W'(side_e_ff.dp_x);
      my_ff      <= MUL_W'(alpha_e_ff) * MUL_W'(side_e_ff.dp_y);
      hit_f_ff   <= !side_e_ff.pinf
                    && (alpha_e_ff >= ZERO_FIX) && (alpha_e_ff <= ONE_FIX)
                    && (beta_e_ff >= ZERO_FIX) && (beta_e_ff <= ONE_FIX);
      if (reset) begin
         vf_ff <= 1'b0;
      end else begin
         vf_ff <= ve_ff;
      end
   end

   // Stage G: point assembly, saturation and the response register.
   logic signed [SUM_W-1:0] bx, by, sx, sy;
   logic signed [PT_W-1:0]  cx_in, cy_in;

   always_comb begin
      bx = SUM_W'($signed({side_f_ff.p1_x, {FRAC_W{1'b0}}}));
      by = SUM_W'($signed({side_f_ff.p1_y, {FRAC_W{1'b0}}}));
      sx = bx + SUM_W'(mx_ff);
      sy = by + SUM_W'(my_ff);
      if (side_f_ff.ptinf) begin
         cx_in = PT_MAX;
         cy_in = PT_MAX;
      end else if (side_f_ff.code != CASE_PROPER) begin
         // A degenerate match is given as p1.
         cx_in = PT_W'(bx);
         cy_in = PT_W'(by);
      end else begin
         cx_in = (sx > SUM_W'(PT_MAX)) ? PT_MAX :
                 (sx < SUM_W'(PT_MIN)) ? PT_MIN : PT_W'(sx);
         cy_in = (sy > SUM_W'(PT_MAX)) ? PT_MAX :
                 (sy < SUM_W'(PT_MIN)) ? PT_MIN : PT_W'(sy);
      end
   end

   logic signed [PAR_W-1:0] alpha_ff, beta_ff;
   logic signed [PT_W-1:0]  cx_ff, cy_ff;
   logic                    pinf_ff, ptinf_ff, hit_ff, rsp_valid_ff;
   case_code_type           code_ff;

   always_ff @(posedge clock) begin
      alpha_ff <= alpha_f_ff;
      beta_ff  <= beta_f_ff;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      pinf_ff  <= side_f_ff.pinf;
      ptinf_ff <= side_f_ff.ptinf;
      hit_ff   <= hit_f_ff;
      code_ff  <= side_f_ff.code;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vf_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_alpha           = alpha_ff;
   assign rsp_beta            = beta_ff;
   assign rsp_cross_x         = cx_ff;
   assign rsp_cross_y         = cy_ff;
   assign rsp_params_infinite = pinf_ff;
   assign rsp_point_infinite  = ptinf_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_case_code       = code_ff;

   // Every response traces back to a transaction a fixed latency earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(req_accept, DIV_LAT + 7))
      else $error("response without a matching request");

   // Both quotient units stay in lockstep.
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      va_out == vb_out)
      else $error("quotient units out of step");

   // A collinear pair has finite parameters but no single point.
   a_collinear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && code_ff == CASE_COLLINEAR) |-> (ptinf_ff && !pinf_ff))
      else $error("collinear flags wrong");

   // Parallel pairs and finite points imply the matching parameter flags.
   a_parallel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && code_ff == CASE_PARALLEL) |-> (ptinf_ff && pinf_ff && !hit_ff))
      else $error("parallel flags wrong");

   a_point_params: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !ptinf_ff) |-> !pinf_ff)
      else $error("finite point with infinite parameters");

endmodule
